// File: hw/rtl/truncated_series_composition_mod_n_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the truncated series composition block.
// Each macro wraps one clocked property that is disabled while reset is low.
// ----------------------------------------------------------------------------
`ifndef TRUNCATED_SERIES_COMPOSITION_MOD_N_TOP_ASSERT_SVH
`define TRUNCATED_SERIES_COMPOSITION_MOD_N_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define TSCN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tscn assertion failed");

// The consequent holds in the cycle after the antecedent.
`define TSCN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tscn assertion failed");

`endif

// File: hw/rtl/tscn_pkg.sv
// ----------------------------------------------------------------------------
// tscn_pkg
// Shared types, codes and the modular adder of the series composition block.
// ----------------------------------------------------------------------------
package tscn_pkg;

    // Length of the result series store.
    localparam int RESULT_TERMS = 64;

    // Operation codes of an input word.
    localparam logic OP_OUTER = 1'b0;
    localparam logic OP_INNER = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_MODULUS   = 1'b0;
    localparam logic REG_PRECISION = 1'b1;

    // Configuration seen by the core.
    typedef struct packed {
        logic [63:0] modulus;
        logic [6:0]  len;
    } cfg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_TERM_CHK,
        ST_TERM_RD,
        ST_TERM_MUL,
        ST_TERM_WB,
        ST_CONST_ISSUE,
        ST_CONST_RD,
        ST_CONST_MUL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    // Sum of two reduced values modulo n; a modulus of zero wraps at 2^64.
    function automatic logic [63:0] add_m(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] n);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (n != 64'd0 && s >= {1'b0, n}) begin
            s = s - {1'b0, n};
        end
        return s[63:0];
    endfunction

endpackage

// File: hw/rtl/tscn_mulmod.sv
// ----------------------------------------------------------------------------
// tscn_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, from the top bit down.
// ----------------------------------------------------------------------------
module tscn_mulmod (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] n,
    output logic        done,
    output logic [63:0] result
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  cnt_reg;
    logic [63:0] a_reg;
    logic [63:0] b_reg;
    logic [63:0] n_reg;
    logic [63:0] r_reg;
    logic [63:0] dbl;
    logic [63:0] r_next;

    // Double, then add a where the current bit of b is set.
    always_comb begin
        dbl    = tscn_pkg::add_m(r_reg, r_reg, n_reg);
        r_next = b_reg[63] ? tscn_pkg::add_m(dbl, a_reg, n_reg) : dbl;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial result.
    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg <= a;
            b_reg <= b;
            n_reg <= n;
            r_reg <= 64'd0;
        end else if (busy_reg) begin
            r_reg <= r_next;
            b_reg <= {b_reg[62:0], 1'b0};
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule

// File: hw/rtl/tscn_cfg.sv
// ----------------------------------------------------------------------------
// tscn_cfg
// Configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module tscn_cfg #(
    parameter int MAX_TERMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output tscn_pkg::cfg_t     cfg
);

    localparam int LIM_INT = (MAX_TERMS < tscn_pkg::RESULT_TERMS) ? MAX_TERMS
                                                                  : tscn_pkg::RESULT_TERMS;
    localparam logic [6:0] LEN_LIMIT = 7'(LIM_INT);

    logic [63:0] modulus_reg;
    logic [6:0]  prec_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // Register writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= 64'd2;
            prec_reg    <= 7'd64;
        end else if (wr_en) begin
            if (paddr[3] == tscn_pkg::REG_MODULUS) begin
                modulus_reg <= pwdata;
            end else begin
                prec_reg <= pwdata[6:0];
            end
        end
    end

    // Read-back and the effective series length.
    always_comb begin
        prdata = (paddr[3] == tscn_pkg::REG_PRECISION) ? {57'd0, prec_reg} : modulus_reg;
        cfg.modulus = modulus_reg;
        cfg.len     = (prec_reg > LEN_LIMIT) ? LEN_LIMIT : prec_reg;
    end

endmodule

// File: hw/rtl/tscn_core.sv
// ----------------------------------------------------------------------------
// tscn_core
// Coefficient stores, Horner sequencer and result emission.
// ----------------------------------------------------------------------------
`include "truncated_series_composition_mod_n_top_assert.svh"

module tscn_core #(
    parameter int MAX_TERMS = 64
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  tscn_pkg::cfg_t     cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  logic [63:0]        s_coefficient,
    input  logic               s_last_coefficient,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_result_coefficient,
    output logic [5:0]         m_position,
    output logic               m_last_result,
    output logic               m_zero_result
);

    localparam int AW = $clog2(MAX_TERMS);
    localparam int CW = $clog2(MAX_TERMS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

    tscn_pkg::state_t state_reg, state_next;

    logic [CW-1:0] outer_count_reg, outer_count_next;
    logic [CW-1:0] inner_count_reg, inner_count_next;
    logic          outer_closed_reg, outer_closed_next;
    logic [6:0]    glen_reg, glen_next;
    logic [CW-1:0] i_reg, i_next;
    logic [5:0]    p_reg, p_next;
    logic [5:0]    j_reg, j_next;
    logic [5:0]    k_reg, k_next;
    logic [5:0]    top_reg, top_next;
    logic          found_reg, found_next;
    logic [63:0]   s_reg, s_next;
    logic          m_valid_reg, m_valid_next;
    logic [63:0]   m_coef_reg, m_coef_next;
    logic [5:0]    m_pos_reg, m_pos_next;
    logic          m_last_reg, m_last_next;
    logic          m_zero_reg, m_zero_next;

    // Memories and their ports.
    logic [63:0] outer_mem [MAX_TERMS];
    logic [63:0] inner_mem [MAX_TERMS];
    logic [63:0] acc_mem [tscn_pkg::RESULT_TERMS];

    logic          outer_we, inner_we, acc_we;
    logic [AW-1:0] outer_waddr, inner_waddr, outer_raddr, inner_raddr;
    logic [5:0]    acc_waddr, acc_raddr;
    logic [63:0]   acc_wdata;
    logic [63:0]   outer_rdata_reg, inner_rdata_reg, acc_rdata_reg;

    // Multiplier hookup.
    logic        mul_start;
    logic [63:0] mul_a, mul_b;
    logic        mul_done;
    logic [63:0] mul_res;

    // Helpers.
    logic [5:0]    diff;
    logic [5:0]    len_m1;
    logic [CW-1:0] base;
    logic [CW-1:0] inner_new;

    tscn_mulmod u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .n       (cfg.modulus),
        .done    (mul_done),
        .result  (mul_res)
    );

    assign diff        = p_reg - j_reg;
    assign len_m1      = 6'(cfg.len - 7'd1);
    assign inner_raddr = AW'(diff);
    assign outer_raddr = AW'(i_reg - CW'(1));

    // Next state and memory control.
    always_comb begin
        state_next        = state_reg;
        outer_count_next  = outer_count_reg;
        inner_count_next  = inner_count_reg;
        outer_closed_next = outer_closed_reg;
        glen_next         = glen_reg;
        i_next            = i_reg;
        p_next            = p_reg;
        j_next            = j_reg;
        k_next            = k_reg;
        top_next          = top_reg;
        found_next        = found_reg;
        s_next            = s_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        m_coef_next       = m_coef_reg;
        m_pos_next        = m_pos_reg;
        m_last_next       = m_last_reg;
        m_zero_next       = m_zero_reg;
        s_ready           = 1'b0;
        outer_we          = 1'b0;
        inner_we          = 1'b0;
        acc_we            = 1'b0;
        outer_waddr       = AW'(outer_count_reg);
        inner_waddr       = AW'(inner_count_reg);
        acc_waddr         = p_reg;
        acc_wdata         = s_reg;
        acc_raddr         = 6'd0;
        mul_start         = 1'b0;
        mul_a             = acc_rdata_reg;
        mul_b             = inner_rdata_reg;
        base              = outer_closed_reg ? CW'(0) : outer_count_reg;
        inner_new         = (inner_count_reg < MAX_CNT) ? inner_count_reg + CW'(1)
                                                        : inner_count_reg;

        case (state_reg)
            tscn_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_operation == tscn_pkg::OP_OUTER) begin
                        outer_waddr       = AW'(base);
                        outer_we          = (base < MAX_CNT);
                        outer_count_next  = (base < MAX_CNT) ? base + CW'(1) : base;
                        outer_closed_next = s_last_coefficient;
                    end else begin
                        inner_we         = (inner_count_reg < MAX_CNT);
                        inner_count_next = inner_new;
                        if (s_last_coefficient) begin
                            inner_count_next = CW'(0);
                            glen_next  = (inner_new < CW'(cfg.len)) ? 7'(inner_new) : cfg.len;
                            found_next = 1'b0;
                            k_next     = 6'd0;
                            state_next = (cfg.len == 7'd0) ? tscn_pkg::ST_EMIT_LD
                                                           : tscn_pkg::ST_CLEAR;
                        end
                    end
                end
            end
            // Zero the accumulator over the series length.
            tscn_pkg::ST_CLEAR: begin
                acc_we    = 1'b1;
                acc_waddr = k_reg;
                acc_wdata = 64'd0;
                if (k_reg == len_m1) begin
                    k_next = 6'd0;
                    if (outer_count_reg == CW'(0)) begin
                        state_next = tscn_pkg::ST_SCAN_RD;
                    end else begin
                        i_next     = outer_count_reg;
                        p_next     = len_m1;
                        j_next     = 6'd0;
                        s_next     = 64'd0;
                        state_next = tscn_pkg::ST_TERM_CHK;
                    end
                end else begin
                    k_next = k_reg + 6'd1;
                end
            end
            // One term acc[j] * g[p-j] of the product, skipped where g is empty.
            tscn_pkg::ST_TERM_CHK: begin
                acc_raddr = j_reg;
                if ({1'b0, diff} < glen_reg) begin
                    state_next = tscn_pkg::ST_TERM_RD;
                end else if (j_reg == p_reg) begin
                    state_next = tscn_pkg::ST_TERM_WB;
                end else begin
                    j_next = j_reg + 6'd1;
                end
            end
            tscn_pkg::ST_TERM_RD: begin
                mul_start  = 1'b1;
                state_next = tscn_pkg::ST_TERM_MUL;
            end
            tscn_pkg::ST_TERM_MUL: begin
                if (mul_done) begin
                    s_next = tscn_pkg::add_m(s_reg, mul_res, cfg.modulus);
                    if (j_reg == p_reg) begin
                        state_next = tscn_pkg::ST_TERM_WB;
                    end else begin
                        j_next     = j_reg + 6'd1;
                        state_next = tscn_pkg::ST_TERM_CHK;
                    end
                end
            end
            // Store the finished coefficient; the product runs from the top down.
            tscn_pkg::ST_TERM_WB: begin
                acc_we = 1'b1;
                if (p_reg == 6'd0) begin
                    state_next = tscn_pkg::ST_CONST_ISSUE;
                end else begin
                    p_next     = p_reg - 6'd1;
                    j_next     = 6'd0;
                    s_next     = 64'd0;
                    state_next = tscn_pkg::ST_TERM_CHK;
                end
            end
            tscn_pkg::ST_CONST_ISSUE: begin
                state_next = tscn_pkg::ST_CONST_RD;
            end
            // Reduce the outer coefficient as 1 * f mod n.
            tscn_pkg::ST_CONST_RD: begin
                mul_start  = 1'b1;
                mul_a      = 64'd1;
                mul_b      = outer_rdata_reg;
                s_next     = acc_rdata_reg;
                state_next = tscn_pkg::ST_CONST_MUL;
            end
            tscn_pkg::ST_CONST_MUL: begin
                if (mul_done) begin
                    acc_we    = 1'b1;
                    acc_waddr = 6'd0;
                    acc_wdata = tscn_pkg::add_m(s_reg, mul_res, cfg.modulus);
                    i_next    = i_reg - CW'(1);
                    if (i_reg == CW'(1)) begin
                        k_next     = 6'd0;
                        state_next = tscn_pkg::ST_SCAN_RD;
                    end else begin
                        p_next     = len_m1;
                        j_next     = 6'd0;
                        s_next     = 64'd0;
                        state_next = tscn_pkg::ST_TERM_CHK;
                    end
                end
            end
            // Find the highest nonzero coefficient.
            tscn_pkg::ST_SCAN_RD: begin
                acc_raddr  = k_reg;
                state_next = tscn_pkg::ST_SCAN_CHK;
            end
            tscn_pkg::ST_SCAN_CHK: begin
                if (acc_rdata_reg != 64'd0) begin
                    top_next   = k_reg;
                    found_next = 1'b1;
                end
                if (k_reg == len_m1) begin
                    k_next     = 6'd0;
                    state_next = (found_next) ? tscn_pkg::ST_EMIT_RD : tscn_pkg::ST_EMIT_LD;
                end else begin
                    k_next     = k_reg + 6'd1;
                    state_next = tscn_pkg::ST_SCAN_RD;
                end
            end
            tscn_pkg::ST_EMIT_RD: begin
                acc_raddr  = k_reg;
                state_next = tscn_pkg::ST_EMIT_LD;
            end
            // Hand a word to the output register once it is free.
            tscn_pkg::ST_EMIT_LD: begin
                acc_raddr = k_reg;
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (!found_reg) begin
                        m_coef_next = 64'd0;
                        m_pos_next  = 6'd0;
                        m_last_next = 1'b1;
                        m_zero_next = 1'b1;
                        state_next  = tscn_pkg::ST_IDLE;
                    end else begin
                        m_coef_next = acc_rdata_reg;
                        m_pos_next  = k_reg;
                        m_last_next = (k_reg == top_reg);
                        m_zero_next = 1'b0;
                        if (k_reg == top_reg) begin
                            state_next = tscn_pkg::ST_IDLE;
                        end else begin
                            k_next     = k_reg + 6'd1;
                            state_next = tscn_pkg::ST_EMIT_RD;
                        end
                    end
                end
            end
            default: begin
                state_next = tscn_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= tscn_pkg::ST_IDLE;
            outer_count_reg  <= CW'(0);
            inner_count_reg  <= CW'(0);
            outer_closed_reg <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            outer_count_reg  <= outer_count_next;
            inner_count_reg  <= inner_count_next;
            outer_closed_reg <= outer_closed_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge aclk) begin
        glen_reg   <= glen_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        top_reg    <= top_next;
        found_reg  <= found_next;
        s_reg      <= s_next;
        m_coef_reg <= m_coef_next;
        m_pos_reg  <= m_pos_next;
        m_last_reg <= m_last_next;
        m_zero_reg <= m_zero_next;
    end

    // Coefficient stores with registered reads.
    always_ff @(posedge aclk) begin
        if (outer_we) begin
            outer_mem[outer_waddr] <= s_coefficient;
        end
        if (inner_we) begin
            inner_mem[inner_waddr] <= s_coefficient;
        end
        if (acc_we) begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        outer_rdata_reg <= outer_mem[outer_raddr];
        inner_rdata_reg <= inner_mem[inner_raddr];
        acc_rdata_reg   <= acc_mem[acc_raddr];
    end

    assign m_valid              = m_valid_reg;
    assign m_result_coefficient = m_coef_reg;
    assign m_position           = m_pos_reg;
    assign m_last_result        = m_last_reg;
    assign m_zero_result        = m_zero_reg;

    // A zero series is one final word with a zero coefficient.
    `TSCN_ASSERT_IMPL(a_zero_word, aclk, aresetn, m_valid_reg && m_zero_reg,
                      m_last_reg && m_coef_reg == 64'd0 && m_pos_reg == 6'd0)
    // Emitted positions never pass the highest nonzero coefficient.
    `TSCN_ASSERT_IMPL(a_pos_bound, aclk, aresetn, m_valid_reg && !m_zero_reg,
                      m_pos_reg <= top_reg)
    // Store counts saturate at the store depth.
    `TSCN_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1,
                      outer_count_reg <= MAX_CNT && inner_count_reg <= MAX_CNT)
    // The last inner word closes the input until the result is out.
    `TSCN_ASSERT_NEXT(a_start_busy, aclk, aresetn,
                      s_valid && s_ready && s_operation == tscn_pkg::OP_INNER
                      && s_last_coefficient, !s_ready)

endmodule

// File: hw/rtl/truncated_series_composition_mod_n_top.sv
// ----------------------------------------------------------------------------
// truncated_series_composition_mod_n_top
// Composes f(g(x)) mod x^N with coefficients modulo a configured modulus.
// ----------------------------------------------------------------------------
// Outer and inner coefficients load at one word per cycle while the block is
// idle. The inner word that carries the last mark starts the composition, and
// no input is taken until its last result word has been loaded into the output
// register. With F outer coefficients, series length L and G inner terms in
// use, the composition first clears the accumulator over the series length,
// then makes F passes of Horner's rule. Each pass checks all L*(L+1)/2 terms,
// runs the multiplier for every product term whose inner coefficient is in use
// (about L*G terms, zero or not), writes back each coefficient and reduces
// the outer coefficient through the multiplier. Then a scan finds the top
// coefficient, and result words are loaded one at a time, each once the output
// register is free. The run time is set by the single bit-serial modular
// multiplier, one bit per cycle, shared by every product and reduction.
// ----------------------------------------------------------------------------
module truncated_series_composition_mod_n_top #(
    parameter int MAX_TERMS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [63:0] s_coefficient,
    input  logic        s_last_coefficient,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_result_coefficient,
    output logic [5:0]  m_position,
    output logic        m_last_result,
    output logic        m_zero_result
);

    tscn_pkg::cfg_t cfg;

    tscn_cfg #(
        .MAX_TERMS (MAX_TERMS)
    ) u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tscn_core #(
        .MAX_TERMS (MAX_TERMS)
    ) u_core (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg                  (cfg),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (s_operation),
        .s_coefficient        (s_coefficient),
        .s_last_coefficient   (s_last_coefficient),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_coefficient (m_result_coefficient),
        .m_position           (m_position),
        .m_last_result        (m_last_result),
        .m_zero_result        (m_zero_result)
    );

endmodule
